>>> hw/rtl/nearest_neighbor_image_scaler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest neighbor image scaler
// Shorthand for clocked implication checks with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_MACROS_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NNIS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NNIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types and constants of the nearest neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

	localparam int REG_W           = 9;
	localparam int REG_MAX         = (2 ** REG_W) - 1;
	localparam int CFG_IDX_W       = 2;
	localparam int PIX_W           = 8;
	localparam int COORD_W         = 8;
	localparam int MAX_DIM_DEF     = 256;
	localparam int STORE_DEPTH_DEF = 65536;

	localparam logic [REG_W-1:0] DIM_RESET = REG_W'(256);

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_FETCH = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH   = 2'd0,
		CFG_SRC_HEIGHT  = 2'd1,
		CFG_TARGET_SIZE = 2'd2,
		CFG_MODE        = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		op_t              op;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0]   out_red;
		logic [PIX_W-1:0]   out_green;
		logic [PIX_W-1:0]   out_blue;
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
		logic               last;
		logic               empty_res;
	} result_t;

endpackage

>>> hw/rtl/nearest_neighbor_image_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Aspect-preserving nearest neighbor scaler over an on-chip frame store.
// ----------------------------------------------------------------------------
// A load transfer writes one pixel into the frame store and leaves busy low,
// so loads may be issued every cycle while no fetch is in progress. A fetch
// transfer raises busy and walks a sequencer that shares one bit-serial
// divider for the output size, the source row and the source column (2*D
// quotient bits each, where D is the dimension width, 9 bits for the default
// sizes), then reads the frame store through a registered read port. The
// source address is first reduced modulo the store depth when it falls
// outside the store, which never happens at the default sizes. An empty
// output image is reported without a division when a size is zero, and after
// the output size division when the other dimension rounds down to zero. The
// result appears for one cycle with result_valid high, in the cycle in which
// busy falls, and the receiver cannot stall it.
`include "nearest_neighbor_image_scaler_macros.svh"

module nearest_neighbor_image_scaler
	import nnis_pkg::*;
#(
	parameter int MAX_DIM     = MAX_DIM_DEF,
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_item_t             item,
	output logic                 result_valid,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	localparam int DIM_MAX = (MAX_DIM > REG_MAX) ? MAX_DIM : REG_MAX;
	localparam int DIM_W   = $clog2(DIM_MAX + 1);
	localparam int DVD_W   = 2 * DIM_W;
	localparam int SD_W    = $clog2(STORE_DEPTH + 1);
	localparam int AW      = $clog2(STORE_DEPTH);
	localparam int DVS_W   = REG_W;

	// The store address is reduced by a reciprocal multiplication that may
	// come out one low, followed by a single conditional subtraction.
	localparam int MOD_SH = DVD_W + AW;
	localparam int RCP_W  = DVD_W + 1;
	localparam int MP_W   = DVD_W + RCP_W;
	localparam logic [RCP_W-1:0] MOD_RECIP =
		RCP_W'((longint'(1) << MOD_SH) / longint'(STORE_DEPTH));

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0_0000_0000_0001,
		S_DIM_MUL  = 13'b0_0000_0000_0010,
		S_DIM_DIV  = 13'b0_0000_0000_0100,
		S_SROW_MUL = 13'b0_0000_0000_1000,
		S_SROW_DIV = 13'b0_0000_0001_0000,
		S_SCOL_MUL = 13'b0_0000_0010_0000,
		S_SCOL_DIV = 13'b0_0000_0100_0000,
		S_ADDR_MUL = 13'b0_0000_1000_0000,
		S_ADDR_ADD = 13'b0_0001_0000_0000,
		S_ADDR_MOD = 13'b0_0010_0000_0000,
		S_ADDR_FIX = 13'b0_0100_0000_0000,
		S_MEM_RD   = 13'b0_1000_0000_0000,
		S_EMIT     = 13'b1_0000_0000_0000
	} state_t;

	function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v);
		return (int'(v) > MAX_DIM) ? REG_W'(MAX_DIM) : v;
	endfunction

	// Configuration and control state.
	state_t           state_q;
	logic [REG_W-1:0] src_width_q;
	logic [REG_W-1:0] src_height_q;
	logic [REG_W-1:0] target_size_q;
	logic             mode_q;
	logic [SD_W-1:0]  load_pos_q;
	logic [DIM_W-1:0] emit_row_q;
	logic [DIM_W-1:0] emit_col_q;
	logic             div_go_q;
	logic             result_valid_q;

	// Datapath registers.
	logic [DVD_W-1:0] prod_q;
	logic [DVS_W-1:0] divisor_q;
	logic [DIM_W-1:0] ow_q;
	logic [DIM_W-1:0] oh_q;
	logic [REG_W-1:0] srow_q;
	logic [REG_W-1:0] scol_q;
	logic [AW-1:0]    addr_q;
	logic [DVD_W-1:0] mod_quo_q;
	logic [3*PIX_W-1:0] rd_q;
	result_t          result_q;

	logic [3*PIX_W-1:0] pixel_mem [STORE_DEPTH];

	logic [REG_W-1:0] sw;
	logic [REG_W-1:0] sh;
	logic [REG_W-1:0] tt;
	logic [REG_W-1:0] chosen;
	logic [REG_W-1:0] other;
	logic             zero_dim;
	logic [DIM_W-1:0] odim;
	logic [DIM_W-1:0] ow;
	logic [DIM_W-1:0] oh;
	logic [DVD_W-1:0] raw_addr;
	logic             raw_in_range;
	logic [MP_W-1:0]  mod_prod;
	logic [31:0]      mod_diff;
	result_t          empty_result;
	logic             row_end;
	logic             col_end;
	logic [31:0]      limit;
	logic [31:0]      pos_eff;
	logic [31:0]      pos_nxt;
	logic [SD_W-1:0]  load_next;
	logic             accept;
	logic             mem_we;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;

	always_comb begin
		sw       = clamp_dim(src_width_q);
		sh       = clamp_dim(src_height_q);
		tt       = clamp_dim(target_size_q);
		chosen   = mode_q ? sh : sw;
		other    = mode_q ? sw : sh;
		zero_dim = (chosen == '0) || (tt == '0) || (other == '0);

		odim = (div_quo > DVD_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : div_quo[DIM_W-1:0];
		ow   = mode_q ? odim : DIM_W'(tt);
		oh   = mode_q ? DIM_W'(tt) : odim;

		raw_addr     = prod_q + DVD_W'(scol_q);
		raw_in_range = (32'(raw_addr) < 32'(STORE_DEPTH));

		mod_prod = MP_W'(prod_q) * MP_W'(MOD_RECIP);
		mod_diff = 32'(prod_q) - 32'(mod_quo_q) * 32'(STORE_DEPTH);

		empty_result           = '0;
		empty_result.last      = 1'b1;
		empty_result.empty_res = 1'b1;

		row_end = (emit_row_q == oh_q - DIM_W'(1));
		col_end = (emit_col_q == ow_q - DIM_W'(1));

		// The load position wraps at the frame size, or at the store depth
		// when the frame is empty or would not fit.
		limit = 32'(sw) * 32'(sh);
		if ((limit == '0) || (limit > 32'(STORE_DEPTH))) begin
			limit = 32'(STORE_DEPTH);
		end
		pos_eff   = (32'(load_pos_q) >= limit) ? '0 : 32'(load_pos_q);
		pos_nxt   = pos_eff + 32'd1;
		load_next = (pos_nxt >= limit) ? '0 : SD_W'(pos_nxt);
	end

	assign busy         = (state_q != S_IDLE);
	assign accept       = start && !busy;
	assign mem_we       = accept && (item.op == OP_LOAD);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	nnis_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (prod_q),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Loads are only taken while the sequencer is idle, so a store write never
	// meets the single store read of a fetch.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pixel_mem[pos_eff[AW-1:0]] <= {item.red, item.green, item.blue};
		end
		if (state_q == S_MEM_RD) begin
			rd_q <= pixel_mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			src_width_q    <= DIM_RESET;
			src_height_q   <= DIM_RESET;
			target_size_q  <= DIM_RESET;
			mode_q         <= 1'b0;
			load_pos_q     <= '0;
			emit_row_q     <= '0;
			emit_col_q     <= '0;
			div_go_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			div_go_q       <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_SRC_WIDTH:   src_width_q   <= cfg_data;
					CFG_SRC_HEIGHT:  src_height_q  <= cfg_data;
					CFG_TARGET_SIZE: target_size_q <= cfg_data;
					CFG_MODE:        mode_q        <= cfg_data[0];
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.op == OP_FETCH) begin
							state_q <= S_DIM_MUL;
						end else begin
							load_pos_q <= load_next;
						end
					end
				end
				S_DIM_MUL: begin
					if (zero_dim) begin
						emit_row_q     <= '0;
						emit_col_q     <= '0;
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= S_DIM_DIV;
					end
				end
				S_DIM_DIV: begin
					if (div_done) begin
						if (odim == '0) begin
							emit_row_q     <= '0;
							emit_col_q     <= '0;
							result_valid_q <= 1'b1;
							state_q        <= S_IDLE;
						end else begin
							// A size change may leave the position off the image.
							if ((emit_row_q >= oh) || (emit_col_q >= ow)) begin
								emit_row_q <= '0;
								emit_col_q <= '0;
							end
							state_q <= S_SROW_MUL;
						end
					end
				end
				S_SROW_MUL: begin
					div_go_q <= 1'b1;
					state_q  <= S_SROW_DIV;
				end
				S_SROW_DIV: begin
					if (div_done) begin
						state_q <= S_SCOL_MUL;
					end
				end
				S_SCOL_MUL: begin
					div_go_q <= 1'b1;
					state_q  <= S_SCOL_DIV;
				end
				S_SCOL_DIV: begin
					if (div_done) begin
						state_q <= S_ADDR_MUL;
					end
				end
				S_ADDR_MUL: begin
					state_q <= S_ADDR_ADD;
				end
				S_ADDR_ADD: begin
					if (raw_in_range) begin
						state_q <= S_MEM_RD;
					end else begin
						state_q <= S_ADDR_MOD;
					end
				end
				S_ADDR_MOD: begin
					state_q <= S_ADDR_FIX;
				end
				S_ADDR_FIX: begin
					state_q <= S_MEM_RD;
				end
				S_MEM_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					result_valid_q <= 1'b1;
					state_q        <= S_IDLE;
					if (col_end) begin
						emit_col_q <= '0;
						emit_row_q <= row_end ? '0 : emit_row_q + DIM_W'(1);
					end else begin
						emit_col_q <= emit_col_q + DIM_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_DIM_MUL: begin
				prod_q    <= DVD_W'(tt) * DVD_W'(other);
				divisor_q <= DVS_W'(chosen);
				if (zero_dim) begin
					result_q <= empty_result;
				end
			end
			S_DIM_DIV: begin
				if (div_done) begin
					ow_q <= ow;
					oh_q <= oh;
					if (odim == '0) begin
						result_q <= empty_result;
					end
				end
			end
			S_SROW_MUL: begin
				prod_q    <= DVD_W'(emit_row_q) * DVD_W'(chosen);
				divisor_q <= DVS_W'(tt);
			end
			S_SROW_DIV: begin
				if (div_done) begin
					srow_q <= div_quo[REG_W-1:0];
				end
			end
			S_SCOL_MUL: begin
				prod_q    <= DVD_W'(emit_col_q) * DVD_W'(chosen);
				divisor_q <= DVS_W'(tt);
			end
			S_SCOL_DIV: begin
				if (div_done) begin
					scol_q <= div_quo[REG_W-1:0];
				end
			end
			S_ADDR_MUL: begin
				prod_q <= DVD_W'(srow_q) * DVD_W'(sw);
			end
			S_ADDR_ADD: begin
				prod_q <= raw_addr;
				addr_q <= AW'(raw_addr);
			end
			S_ADDR_MOD: begin
				mod_quo_q <= DVD_W'(mod_prod >> MOD_SH);
			end
			S_ADDR_FIX: begin
				addr_q <= (mod_diff >= 32'(STORE_DEPTH)) ? AW'(mod_diff - 32'(STORE_DEPTH))
					: AW'(mod_diff);
			end
			S_EMIT: begin
				result_q.out_red   <= rd_q[3*PIX_W-1:2*PIX_W];
				result_q.out_green <= rd_q[2*PIX_W-1:PIX_W];
				result_q.out_blue  <= rd_q[PIX_W-1:0];
				result_q.out_row   <= emit_row_q[COORD_W-1:0];
				result_q.out_col   <= emit_col_q[COORD_W-1:0];
				result_q.last      <= row_end && col_end;
				result_q.empty_res <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	`NNIS_ASSERT_NEXT(a_strobe_single, clk, arst_n, result_valid_q, !result_valid_q, "result strobe held longer than one cycle")
	`NNIS_ASSERT_IMPLY(a_fetch_ends_in_result, clk, arst_n, $fell(busy), result_valid_q, "fetch finished without a result transfer")
	`NNIS_ASSERT_IMPLY(a_empty_is_blank, clk, arst_n, result_valid_q && result_q.empty_res, result_q.last && (result_q.out_row == '0) && (result_q.out_col == '0), "empty result is not a blank last pixel")
	`NNIS_ASSERT_IMPLY(a_div_done_in_wait, clk, arst_n, div_done, (state_q == S_DIM_DIV) || (state_q == S_SROW_DIV) || (state_q == S_SCOL_DIV), "divider finished outside a wait state")

endmodule

>>> hw/rtl/nnis_div.sv
// ----------------------------------------------------------------------------
// nnis_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnis_div
	import nnis_pkg::*;
#(
	parameter int DVD_W = 2 * REG_W,
	parameter int DVS_W = REG_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   trial;
	logic             fits;

	always_comb begin
		shifted = {rem_q, dvd_q[DVD_W-1]};
		fits    = (shifted >= {1'b0, dvs_q});
		trial   = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// The dividend register shifts out its top bit each step and takes the
	// new quotient bit at the bottom, so it ends up holding the quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
